FILE: hdl/swsb_pkg.sv
`default_nettype none

package swsb_pkg;

	localparam int SEQ_W     = 32;
	localparam int LEN_W     = 11;
	localparam int HDL_W     = 16;
	localparam int WSIZE_W   = 7;
	localparam int MAX_SLOTS = 64;
	localparam int SLOT_W    = $clog2(MAX_SLOTS);
	// effective window size spans 1..MAX_SLOTS, so one bit more than a slot index
	localparam int EFF_W     = SLOT_W + 1;

	// remainder unit: bits of the dividend retired per cycle
	localparam int REM_BITS  = 8;
	localparam int REM_STEPS = SEQ_W / REM_BITS;
	localparam int STEP_W    = $clog2(REM_STEPS);

	localparam int WSIZE_RST = 64;

	localparam logic [1:0] OP_ADD  = 2'd0;
	localparam logic [1:0] OP_FIND = 2'd1;
	localparam logic [1:0] OP_ACK  = 2'd2;

	typedef struct packed {
		logic [SEQ_W-1:0] seq;
		logic [LEN_W-1:0] len;
		logic [HDL_W-1:0] handle;
	} slot_entry_t;

	typedef struct packed {
		logic load;      // latch the input word, start the remainder
		logic mem_wr;    // store entry in its slot, mark it valid
		logic mem_rd;    // read the addressed slot
		logic sweep;     // ack sweep over the slots in use
		logic commit;    // load the result register, move the edges
		logic find_res;  // result carries the find fields
		logic ack_res;   // result follows an ack
	} swsb_cmd_t;

	typedef struct packed {
		logic rem_last;
		logic sweep_done;
		logic out_free;
	} swsb_sts_t;

endpackage

`default_nettype wire

FILE: hdl/swsb_rem.sv
`default_nettype none

module swsb_rem import swsb_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [SEQ_W-1:0] dividend,
	input  logic [EFF_W-1:0] divisor,
	output logic [EFF_W-1:0] rem,
	output logic             last
);

	logic              busy_q;
	logic [STEP_W-1:0] cnt_q;
	logic [SEQ_W-1:0]  dvd_q;
	logic [EFF_W-1:0]  rem_q;
	logic [EFF_W-1:0]  rem_n;
	logic [EFF_W-1:0]  r;

	// restoring remainder, REM_BITS dividend bits per cycle; r stays below divisor
	always_comb begin
		r = rem_q;
		for (int k = 0; k < REM_BITS; k++) begin
			r = {r[EFF_W-2:0], dvd_q[SEQ_W-1-k]};
			if (r >= divisor) begin
				r = r - divisor;
			end
		end
		rem_n = r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == STEP_W'(REM_STEPS - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= dvd_q << REM_BITS;
			rem_q <= rem_n;
		end
	end

	assign rem  = rem_q;
	assign last = busy_q && (cnt_q == STEP_W'(REM_STEPS - 1));

endmodule

`default_nettype wire

FILE: hdl/swsb_dp.sv
`default_nettype none

module swsb_dp import swsb_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  swsb_cmd_t          cmd,
	output swsb_sts_t          sts,
	input  logic [SEQ_W-1:0]   seq_num,
	input  logic [LEN_W-1:0]   pdu_length,
	input  logic [HDL_W-1:0]   buffer_handle,
	input  logic               cfg_we,
	input  logic [WSIZE_W-1:0] window_size,
	input  logic               out_stall,
	output logic               out_valid,
	output logic               hit,
	output logic [SEQ_W-1:0]   found_seq,
	output logic [LEN_W-1:0]   found_length,
	output logic [HDL_W-1:0]   found_handle,
	output logic               window_open,
	output logic [SEQ_W-1:0]   window_low,
	output logic [SEQ_W-1:0]   window_high
);

	localparam int HIGH_RST = (WSIZE_RST > MAX_SLOTS) ? MAX_SLOTS : WSIZE_RST;

	logic [WSIZE_W-1:0] wsz_q;
	logic [EFF_W-1:0]   eff_w;
	logic [SEQ_W-1:0]   seq_q;
	logic [LEN_W-1:0]   len_q;
	logic [HDL_W-1:0]   handle_q;
	logic [SEQ_W-1:0]   low_q;
	logic [SEQ_W-1:0]   high_q;
	logic [SEQ_W-1:0]   next_q;
	logic [EFF_W-1:0]   rem;
	logic [SLOT_W-1:0]  slot;
	logic               rem_last;
	logic               sweep_done;

	logic [MAX_SLOTS-1:0] slot_valid_q;
	slot_entry_t          mem [MAX_SLOTS];
	slot_entry_t          mem_rd_q;
	logic                 rd_en;
	logic [SLOT_W-1:0]    rd_addr;

	logic [EFF_W-1:0]  sw_cnt_q;
	logic              sw_issue;
	logic              cmp_vld_s1;
	logic [SLOT_W-1:0] cmp_idx_s1;
	logic              clr;

	logic             hit_n;
	logic [SEQ_W-1:0] low_n;
	logic [SEQ_W-1:0] high_n;

	logic             out_valid_q;
	logic             hit_q;
	logic [SEQ_W-1:0] found_seq_q;
	logic [LEN_W-1:0] found_length_q;
	logic [HDL_W-1:0] found_handle_q;
	logic             window_open_q;
	logic [SEQ_W-1:0] window_low_q;
	logic [SEQ_W-1:0] window_high_q;

	// zero acts as one, oversize clamps to the table depth
	always_comb begin
		if (wsz_q == '0) begin
			eff_w = EFF_W'(1);
		end else if (int'(wsz_q) > MAX_SLOTS) begin
			eff_w = EFF_W'(MAX_SLOTS);
		end else begin
			eff_w = EFF_W'(wsz_q);
		end
	end

	swsb_rem u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.load),
		.dividend (seq_num),
		.divisor  (eff_w),
		.rem      (rem),
		.last     (rem_last)
	);

	assign slot = rem[SLOT_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			seq_q    <= seq_num;
			len_q    <= pdu_length;
			handle_q <= buffer_handle;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wsz_q <= WSIZE_W'(WSIZE_RST);
		end else if (cfg_we) begin
			wsz_q <= window_size;
		end
	end

	// ack sweep: read one slot a cycle, compare in the next
	assign sw_issue = cmd.sweep && (sw_cnt_q < eff_w);
	assign rd_en    = cmd.mem_rd || sw_issue;
	assign rd_addr  = cmd.mem_rd ? slot : sw_cnt_q[SLOT_W-1:0];
	assign clr      = cmp_vld_s1 && slot_valid_q[cmp_idx_s1] && (mem_rd_q.seq < seq_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sw_cnt_q   <= '0;
			cmp_vld_s1 <= 1'b0;
			cmp_idx_s1 <= '0;
		end else begin
			cmp_vld_s1 <= sw_issue;
			cmp_idx_s1 <= sw_cnt_q[SLOT_W-1:0];
			if (cmd.load) begin
				sw_cnt_q <= '0;
			end else if (sw_issue) begin
				sw_cnt_q <= sw_cnt_q + 1'b1;
			end
		end
	end

	assign sweep_done = cmd.sweep && !sw_issue && !cmp_vld_s1;

	always_ff @(posedge clk) begin
		if (cmd.mem_wr) begin
			mem[slot] <= slot_entry_t'{seq: seq_q, len: len_q, handle: handle_q};
		end
		if (rd_en) begin
			mem_rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_q <= '0;
		end else begin
			if (cmd.mem_wr) begin
				slot_valid_q[slot] <= 1'b1;
			end
			if (clr) begin
				slot_valid_q[cmp_idx_s1] <= 1'b0;
			end
		end
	end

	// window edges after this word
	always_comb begin
		low_n  = low_q;
		high_n = high_q;
		if (cmd.ack_res && (low_q < seq_q)) begin
			low_n  = seq_q;
			high_n = seq_q + {{(SEQ_W-EFF_W){1'b0}}, eff_w};
		end
	end

	assign hit_n = cmd.find_res && slot_valid_q[slot];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q  <= '0;
			high_q <= SEQ_W'(HIGH_RST);
			next_q <= '0;
		end else begin
			if (cmd.mem_wr) begin
				next_q <= seq_q + 1'b1;
			end
			if (cmd.commit) begin
				low_q  <= low_n;
				high_q <= high_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			hit_q          <= hit_n;
			found_seq_q    <= hit_n ? mem_rd_q.seq : '0;
			found_length_q <= hit_n ? mem_rd_q.len : '0;
			found_handle_q <= hit_n ? mem_rd_q.handle : '0;
			window_open_q  <= high_n > next_q;
			window_low_q   <= low_n;
			window_high_q  <= high_n;
		end
	end

	assign sts = '{rem_last: rem_last, sweep_done: sweep_done,
		out_free: (!out_valid_q || !out_stall)};

	assign out_valid    = out_valid_q;
	assign hit          = hit_q;
	assign found_seq    = found_seq_q;
	assign found_length = found_length_q;
	assign found_handle = found_handle_q;
	assign window_open  = window_open_q;
	assign window_low   = window_low_q;
	assign window_high  = window_high_q;

endmodule

`default_nettype wire

FILE: hdl/swsb_ctrl.sv
`default_nettype none

module swsb_ctrl import swsb_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [1:0] op,
	input  swsb_sts_t  sts,
	output logic       in_stall,
	output logic       cfg_ready,
	output swsb_cmd_t  cmd
);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_REM   = 6'b000010,
		ST_ADD   = 6'b000100,
		ST_FRD   = 6'b001000,
		ST_SWEEP = 6'b010000,
		ST_DONE  = 6'b100000
	} state_t;

	state_t     state_q;
	state_t     state_n;
	logic [1:0] op_q;
	logic       idle;

	assign idle      = (state_q == ST_IDLE);
	assign in_stall  = !idle;
	assign cfg_ready = idle;

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					unique case (op) inside
						OP_ADD, OP_FIND: state_n = ST_REM;
						OP_ACK:          state_n = ST_SWEEP;
						default:         state_n = ST_DONE;
					endcase
				end
			end
			ST_REM: begin
				if (sts.rem_last) begin
					state_n = (op_q == OP_ADD) ? ST_ADD : ST_FRD;
				end
			end
			ST_ADD:   state_n = ST_DONE;
			ST_FRD:   state_n = ST_DONE;
			ST_SWEEP: begin
				if (sts.sweep_done) begin
					state_n = ST_DONE;
				end
			end
			ST_DONE: begin
				if (sts.out_free) begin
					state_n = ST_IDLE;
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= OP_ADD;
		end else begin
			state_q <= state_n;
			if (idle && in_valid) begin
				op_q <= op;
			end
		end
	end

	always_comb begin
		cmd          = '0;
		cmd.load     = idle && in_valid;
		cmd.mem_wr   = (state_q == ST_ADD);
		cmd.mem_rd   = (state_q == ST_FRD);
		cmd.sweep    = (state_q == ST_SWEEP);
		cmd.commit   = (state_q == ST_DONE) && sts.out_free;
		cmd.find_res = (op_q == OP_FIND);
		cmd.ack_res  = (op_q == OP_ACK);
	end

endmodule

`default_nettype wire

FILE: hdl/sliding_window_send_buffer.sv
// Add and find: the remainder unit forms the slot index, the slot is written (add) or read
// (find), then the result is committed. Ack: one slot of the table read and compared per
// cycle over the effective window size, then the result is committed. Unused op: commit only.
// Next word taken after the commit. Remainder unit retires 8 bits of seq_num a cycle.
// Asynchronous active-low reset clears the valid bits, low edge, next sequence and
// sets high edge and window size to 64; table contents are left as they are.
`default_nettype none

module sliding_window_send_buffer import swsb_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         op,
	input  logic [SEQ_W-1:0]   seq_num,
	input  logic [LEN_W-1:0]   pdu_length,
	input  logic [HDL_W-1:0]   buffer_handle,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               hit,
	output logic [SEQ_W-1:0]   found_seq,
	output logic [LEN_W-1:0]   found_length,
	output logic [HDL_W-1:0]   found_handle,
	output logic               window_open,
	output logic [SEQ_W-1:0]   window_low,
	output logic [SEQ_W-1:0]   window_high,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [WSIZE_W-1:0] window_size
);

	swsb_cmd_t cmd;
	swsb_sts_t sts;

	swsb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.op        (op),
		.sts       (sts),
		.in_stall  (in_stall),
		.cfg_ready (cfg_ready),
		.cmd       (cmd)
	);

	swsb_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.seq_num       (seq_num),
		.pdu_length    (pdu_length),
		.buffer_handle (buffer_handle),
		.cfg_we        (cfg_valid && cfg_ready),
		.window_size   (window_size),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.hit           (hit),
		.found_seq     (found_seq),
		.found_length  (found_length),
		.found_handle  (found_handle),
		.window_open   (window_open),
		.window_low    (window_low),
		.window_high   (window_high)
	);

	// a result word must never overwrite one still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!out_valid || !out_stall))
		else $error("result register overwritten while stalled");

	// a taken word leaves idle, so no config write can slip in behind it
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> !cfg_ready)
		else $error("block still idle after taking a word");

	// only a find may report a hit
	a_hit_only_find: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && !cmd.find_res) |=> (out_valid && !hit))
		else $error("hit reported for a non-find word");

endmodule

`default_nettype wire
